@@ rtl/counted_adjacency_matrix_store_macros.svh @@
// assertion helpers used by the checker
`ifndef COUNTED_ADJACENCY_MATRIX_STORE_MACROS_SVH
`define COUNTED_ADJACENCY_MATRIX_STORE_MACROS_SVH

// same-cycle implication, held off during reset
`define CAMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define CAMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cams_pkg.sv @@
`timescale 1ns / 1ps

package cams_pkg;

  // graph size and count width
  localparam int NODE_COUNT  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int NODE_W      = $clog2(NODE_COUNT);
  localparam int CELL_COUNT  = NODE_COUNT * NODE_COUNT;
  localparam int ADDR_W      = 2 * NODE_W;
  localparam int KIND_W      = 3;

  localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
  localparam logic [NODE_W-1:0]      IDX_LAST = NODE_W'(NODE_COUNT - 1);

  // operation kinds
  localparam logic [KIND_W-1:0] K_SET = 3'd0;
  localparam logic [KIND_W-1:0] K_INC = 3'd1;
  localparam logic [KIND_W-1:0] K_DEC = 3'd2;
  localparam logic [KIND_W-1:0] K_INS = 3'd3;
  localparam logic [KIND_W-1:0] K_DEL = 3'd4;

  // read port address selection
  localparam int RD_W = 2;
  localparam logic [RD_W-1:0] RD_NONE = 2'd0;
  localparam logic [RD_W-1:0] RD_EDGE = 2'd1;
  localparam logic [RD_W-1:0] RD_ROWX = 2'd2;
  localparam logic [RD_W-1:0] RD_COLX = 2'd3;

  // jump conditions
  localparam int CND_W = 3;
  localparam logic [CND_W-1:0] C_NEVER    = 3'd0;
  localparam logic [CND_W-1:0] C_NO_IN    = 3'd1;
  localparam logic [CND_W-1:0] C_NO_SCAN  = 3'd2;
  localparam logic [CND_W-1:0] C_IDX_MORE = 3'd3;
  localparam logic [CND_W-1:0] C_OUT_BUSY = 3'd4;

  // program steps; the last step falls through to the first
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] S_FETCH  = 3'd0;
  localparam logic [PC_W-1:0] S_READ   = 3'd1;
  localparam logic [PC_W-1:0] S_UPDATE = 3'd2;
  localparam logic [PC_W-1:0] S_ROW    = 3'd3;
  localparam logic [PC_W-1:0] S_COL    = 3'd4;
  localparam logic [PC_W-1:0] S_DRAIN  = 3'd5;
  localparam logic [PC_W-1:0] S_APPLY  = 3'd6;
  localparam logic [PC_W-1:0] S_OUT    = 3'd7;

  typedef struct packed {
    logic            in_rdy;
    logic [RD_W-1:0] rd;
    logic            upd;
    logic            idx_inc;
    logic            apply;
    logic            out_ld;
    logic [CND_W-1:0] cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic scan_req;
    logic idx_more;
    logic out_busy;
  } stat_t;

  // control store
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    w.cond = C_NEVER;
    w.rd   = RD_NONE;
    case (pc)
      S_FETCH: begin
        w.in_rdy = 1'b1;
        w.cond   = C_NO_IN;
        w.target = S_FETCH;
      end
      S_READ: begin
        w.rd = RD_EDGE;
      end
      S_UPDATE: begin
        w.upd    = 1'b1;
        w.cond   = C_NO_SCAN;
        w.target = S_OUT;
      end
      S_ROW: begin
        w.rd = RD_ROWX;
      end
      S_COL: begin
        w.rd      = RD_COLX;
        w.idx_inc = 1'b1;
        w.cond    = C_IDX_MORE;
        w.target  = S_ROW;
      end
      S_DRAIN: begin
        w.cond = C_NEVER;
      end
      S_APPLY: begin
        w.apply = 1'b1;
      end
      S_OUT: begin
        w.out_ld = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.target = S_OUT;
      end
      default: begin
        w.cond = C_NEVER;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/cams_ram.sv @@
`timescale 1ns / 1ps

module cams_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

@@ rtl/cams_seq.sv @@
`timescale 1ns / 1ps

module cams_seq
  import cams_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            jump;

  // control word for the current step
  assign ctrl = ucode(pc_r);

  // jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_IN:    jump = !stat.in_valid;
      C_NO_SCAN:  jump = !stat.scan_req;
      C_IDX_MORE: jump = stat.idx_more;
      C_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
  end

  assign pc_nxt = jump ? ctrl.target : pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/cams_dp.sv @@
`timescale 1ns / 1ps

module cams_dp
  import cams_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_t                  ctrl,
  output stat_t                  stat,
  input  logic                   in_valid,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [NODE_W-1:0]      in_row_node,
  input  logic [NODE_W-1:0]      in_col_node,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_WIDTH-1:0] out_edge_count,
  output logic                   out_row_present,
  output logic                   out_col_present
);

  logic [KIND_W-1:0]      kind_r;
  logic [NODE_W-1:0]      row_r, col_r, idx_r, idx_nxt, rd_idx_r;
  logic [RD_W-1:0]        rd_kind_r;
  logic [NODE_COUNT-1:0]  flag_r, flag_nxt;
  logic [CELL_COUNT-1:0]  vld_r;
  logic                   vld_a_r, vld_b_r;
  logic                   keep_row_r, keep_col_r;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] rd_a, rd_b, cur, new_cnt;
  logic [ADDR_W-1:0]      addr_a, addr_b, waddr;
  logic                   we, scan_req, in_fire, out_busy, nz, skip;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0] out_cnt_r;
  logic                   out_row_r, out_col_r;

  assign in_fire  = in_valid & ctrl.in_rdy;
  assign out_busy = out_valid_r & !out_ready;
  assign waddr    = {row_r, col_r};

  // read address selection
  always_comb begin
    case (ctrl.rd)
      RD_ROWX: begin
        addr_a = {row_r, idx_r};
        addr_b = {idx_r, row_r};
      end
      RD_COLX: begin
        addr_a = {col_r, idx_r};
        addr_b = {idx_r, col_r};
      end
      default: begin
        addr_a = {row_r, col_r};
        addr_b = {row_r, col_r};
      end
    endcase
  end

  cams_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (new_cnt),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // never-written cells read as zero
  assign cur = vld_a_r ? rd_a : CNT_ZERO;
  assign nz  = (vld_a_r & (|rd_a)) | (vld_b_r & (|rd_b));
  assign skip = (rd_idx_r == row_r) || (rd_idx_r == col_r);

  // edge update, node operations and flag clearing after a scan
  always_comb begin
    flag_nxt = flag_r;
    new_cnt  = cur;
    we       = 1'b0;
    scan_req = 1'b0;
    if (ctrl.upd) begin
      case (kind_r)
        K_SET, K_INC: begin
          if (row_r != col_r) begin
            we = 1'b1;
            if (kind_r == K_SET || cur == CNT_ZERO) begin
              new_cnt         = CNT_ONE;
              flag_nxt[row_r] = 1'b1;
              flag_nxt[col_r] = 1'b1;
            end else if (cur != CNT_MAX) begin
              new_cnt = cur + 1'b1;
            end
          end
        end
        K_DEC: begin
          if (row_r != col_r) begin
            we = 1'b1;
            if (cur != CNT_ZERO) begin
              new_cnt = cur - 1'b1;
            end
            scan_req = (new_cnt == CNT_ZERO) & flag_r[row_r] & flag_r[col_r];
          end
        end
        K_INS: flag_nxt[row_r] = 1'b1;
        K_DEL: flag_nxt[row_r] = 1'b0;
        default: flag_nxt = flag_r;
      endcase
    end
    if (ctrl.apply) begin
      if (!keep_row_r) begin
        flag_nxt[row_r] = 1'b0;
      end
      if (!keep_col_r) begin
        flag_nxt[col_r] = 1'b0;
      end
    end
  end

  // scan index
  always_comb begin
    idx_nxt = idx_r;
    if (in_fire) begin
      idx_nxt = '0;
    end else if (ctrl.idx_inc) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.out_ld && !out_busy) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= '0;
      vld_r       <= '0;
      idx_r       <= '0;
      rd_kind_r   <= RD_NONE;
      keep_row_r  <= 1'b0;
      keep_col_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      idx_r       <= idx_nxt;
      rd_kind_r   <= ctrl.rd;
      out_valid_r <= out_valid_nxt;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      // a node is kept if any neighbour other than the pair still has an edge
      if (in_fire) begin
        keep_row_r <= 1'b0;
        keep_col_r <= 1'b0;
      end else begin
        if (rd_kind_r == RD_ROWX && !skip && nz) begin
          keep_row_r <= 1'b1;
        end
        if (rd_kind_r == RD_COLX && !skip && nz) begin
          keep_col_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    vld_a_r  <= vld_r[addr_a];
    vld_b_r  <= vld_r[addr_b];
    rd_idx_r <= idx_r;
    if (in_fire) begin
      kind_r <= in_kind;
      row_r  <= in_row_node;
      col_r  <= in_col_node;
    end
    if (ctrl.upd) begin
      cnt_r <= new_cnt;
    end
    if (ctrl.out_ld && !out_busy) begin
      out_cnt_r <= cnt_r;
      out_row_r <= flag_r[row_r];
      out_col_r <= flag_r[col_r];
    end
  end

  assign stat.in_valid = in_valid;
  assign stat.scan_req = scan_req;
  assign stat.idx_more = (idx_r != IDX_LAST);
  assign stat.out_busy = out_busy;

  assign out_valid       = out_valid_r;
  assign out_edge_count  = out_cnt_r;
  assign out_row_present = out_row_r;
  assign out_col_present = out_col_r;

endmodule

@@ rtl/counted_adjacency_matrix_store.sv @@
// each item runs the FETCH, READ, UPDATE and OUT steps; the result register is loaded in OUT
// a decrease to zero with both nodes present scans row and column in ROW, COL, DRAIN, APPLY
// the step program takes no new item until the last one has passed the OUT step
// the result register frees the input side while a result beat waits
// reset: synchronous active-low rst_n clears node flags, cell valid bits and the sequencer
`timescale 1ns / 1ps

module counted_adjacency_matrix_store
  import cams_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [NODE_W-1:0]      in_row_node,
  input  logic [NODE_W-1:0]      in_col_node,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COUNT_WIDTH-1:0] out_edge_count,
  output logic                   out_row_present,
  output logic                   out_col_present
);

  ctrl_t ctrl;
  stat_t stat;

  // microprogram sequencer
  cams_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // edge memory, node flags and result register
  cams_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_valid        (in_valid),
    .in_kind         (in_kind),
    .in_row_node     (in_row_node),
    .in_col_node     (in_col_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_edge_count  (out_edge_count),
    .out_row_present (out_row_present),
    .out_col_present (out_col_present)
  );

  assign in_ready = ctrl.in_rdy;

endmodule

@@ rtl/cams_chk.sv @@
`timescale 1ns / 1ps
`include "counted_adjacency_matrix_store_macros.svh"

module cams_chk
  import cams_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COUNT_WIDTH-1:0] out_edge_count,
  input logic                   out_row_present,
  input logic                   out_col_present
);

  // a stalled result beat holds
  `CAMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_edge_count) && $stable(out_row_present) && $stable(out_col_present), "result beat changed while stalled")

  // one item in flight: no new beat taken right after one is accepted
  `CAMS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while an item is in flight")

  // a result never appears before the read and update steps that follow an accepted beat have run
  `CAMS_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid) ##1 !$rose(out_valid), "result too early")

  // a new result coincides with the input side opening again
  `CAMS_ASSERT_NOW(a_reopen, $rose(out_valid), in_ready, "input side not reopened with the result")

endmodule

bind counted_adjacency_matrix_store cams_chk u_cams_chk (.*);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import cams_pkg::*;

  // kinds without a package constant; all three read back without a change
  localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int RESET_CYCLES  = 11;
  localparam int SCAN_CYCLES   = 2 * NODE_COUNT + 6;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PRINT_LIMIT   = 40;
  localparam int PHASE_ITEMS   = 350;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] count;
    logic                   row_up;
    logic                   col_up;
  } graph_view_t;

  // mirror of the graph store, one expected view per accepted beat
  class edge_store_scoreboard;
    bit                     node_up [NODE_COUNT];
    logic [COUNT_WIDTH-1:0] use_count [NODE_COUNT][NODE_COUNT];
    graph_view_t            awaited [$];
    int                     errors;
    int                     checked;
    int                     scans;

    function new();
      foreach (node_up[i]) node_up[i] = 1'b0;
      foreach (use_count[i, j]) use_count[i][j] = CNT_ZERO;
      errors  = 0;
      checked = 0;
      scans   = 0;
    endfunction

    // does node n keep an edge to or from any node other than a and b
    function bit linked_elsewhere(int n, int a, int b);
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (i == a || i == b) continue;
        if (use_count[n][i] != CNT_ZERO || use_count[i][n] != CNT_ZERO) return 1'b1;
      end
      return 1'b0;
    endfunction

    task report(input string msg);
      if (errors < PRINT_LIMIT) $display("mismatch: %s", msg);
      errors++;
    endtask

    // apply one operation to the mirror and queue the view it leaves
    task note_input(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] r,
                    input logic [NODE_W-1:0] c);
      graph_view_t v;
      bit          keep_r;
      bit          keep_c;
      if ((k == K_SET || k == K_INC || k == K_DEC) && r != c) begin
        if (k == K_SET || (k == K_INC && use_count[r][c] == CNT_ZERO)) begin
          node_up[r]      = 1'b1;
          node_up[c]      = 1'b1;
          use_count[r][c] = CNT_ONE;
        end else if (k == K_INC) begin
          if (use_count[r][c] != CNT_MAX) use_count[r][c] = use_count[r][c] + 1'b1;
        end else begin
          if (use_count[r][c] != CNT_ZERO) use_count[r][c] = use_count[r][c] - 1'b1;
          // last use gone: endpoints with no other link drop out
          if (use_count[r][c] == CNT_ZERO && node_up[r] && node_up[c]) begin
            keep_r = linked_elsewhere(r, r, c);
            keep_c = linked_elsewhere(c, r, c);
            if (!keep_r) node_up[r] = 1'b0;
            if (!keep_c) node_up[c] = 1'b0;
            scans++;
          end
        end
      end else if (k == K_INS) begin
        node_up[r] = 1'b1;
      end else if (k == K_DEL) begin
        node_up[r] = 1'b0;
      end
      v.count  = use_count[r][c];
      v.row_up = node_up[r];
      v.col_up = node_up[c];
      awaited.push_back(v);
    endtask

    // compare a result beat with the oldest expected view
    task check_result(input logic [COUNT_WIDTH-1:0] cnt, input logic rp, input logic cp);
      graph_view_t v;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing expected (count %0d)", cnt));
      end else begin
        v = awaited.pop_front();
        if (cnt !== v.count)
          report($sformatf("result %0d: edge count %0d, expected %0d", checked, cnt, v.count));
        if (rp !== v.row_up)
          report($sformatf("result %0d: row flag %b, expected %b", checked, rp, v.row_up));
        if (cp !== v.col_up)
          report($sformatf("result %0d: col flag %b, expected %b", checked, cp, v.col_up));
      end
      checked++;
    endtask
  endclass

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [KIND_W-1:0]      in_kind = KIND_QUERY;
  logic [NODE_W-1:0]      in_row_node = '0;
  logic [NODE_W-1:0]      in_col_node = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [COUNT_WIDTH-1:0] out_edge_count;
  logic                   out_row_present;
  logic                   out_col_present;

  int                     send_idle_pct  = 0;
  int                     recv_stall_pct = 0;
  int                     cycle_count    = 0;
  edge_store_scoreboard   sb = new();

  counted_adjacency_matrix_store u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_row_node     (in_row_node),
    .in_col_node     (in_col_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_edge_count  (out_edge_count),
    .out_row_present (out_row_present),
    .out_col_present (out_col_present)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // beat monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_input(in_kind, in_row_node, in_col_node);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_edge_count, out_row_present, out_col_present);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[counted_adjacency_matrix_store] ERROR");
      $finish;
    end
  end

  // one input beat, with a random gap in front of it
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [NODE_W-1:0] r,
                           input logic [NODE_W-1:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= k;
    in_row_node <= r;
    in_col_node <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly a handful of nodes so the graph gets dense
  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(99) < 70) return NODE_W'($urandom_range(5));
    return NODE_W'($urandom_range(NODE_COUNT - 1));
  endfunction

  // weighted operation mix, returns whether the beat does real work
  task automatic send_random_item(output bit useful);
    logic [KIND_W-1:0] k;
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] c;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 22)      k = K_SET;
    else if (pick < 45) k = K_INC;
    else if (pick < 72) k = K_DEC;
    else if (pick < 79) k = K_INS;
    else if (pick < 86) k = K_DEL;
    else if (pick < 94) k = KIND_QUERY;
    else if (pick < 97) k = KIND_SPARE_LO;
    else                k = KIND_SPARE_HI;
    r = pick_node();
    c = pick_node();
    send_item(k, r, c);
    useful = !((k == K_SET || k == K_INC || k == K_DEC) && r == c);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
    int done;
    bit useful;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < items) begin
      send_random_item(useful);
      if (useful) done++;
    end
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    // reset
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct  = 13;
    recv_stall_pct = 79;

    // directed: extremes, every kind, self edges, scans that drop or keep nodes
    send_item(KIND_QUERY, 4'd0, 4'd15);
    send_item(K_SET, 4'd0, 4'd15);
    send_item(K_SET, 4'd5, 4'd5);
    send_item(K_INC, 4'd9, 4'd9);
    send_item(K_DEC, 4'd15, 4'd15);
    send_item(K_INC, 4'd3, 4'd4);
    send_item(K_INC, 4'd3, 4'd4);
    send_item(K_INC, 4'd3, 4'd4);
    send_item(K_DEC, 4'd3, 4'd4);
    send_item(K_DEC, 4'd3, 4'd4);
    send_item(K_DEC, 4'd3, 4'd4);
    send_item(K_SET, 4'd1, 4'd2);
    send_item(K_SET, 4'd2, 4'd7);
    send_item(K_DEC, 4'd1, 4'd2);
    send_item(K_DEC, 4'd1, 4'd2);
    send_item(K_INS, 4'd1, 4'd0);
    send_item(K_DEC, 4'd1, 4'd2);
    send_item(K_DEL, 4'd15, 4'd0);
    send_item(KIND_QUERY, 4'd15, 4'd0);
    send_item(K_INS, 4'd15, 4'd15);
    send_item(KIND_SPARE_LO, 4'd0, 4'd15);
    send_item(KIND_SPARE_HI, 4'd15, 4'd0);
    send_item(K_DEC, 4'd0, 4'd15);
    send_item(K_DEC, 4'd2, 4'd7);

    // random, three idling mixes
    run_phase(13, 79, PHASE_ITEMS);
    run_phase(79, 13, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    repeat (SCAN_CYCLES + 4) @(posedge clk);
    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.awaited.size()));

    $display("checked %0d result beats under three back-pressure mixes", sb.checked);
    $display("%0d decreases to zero ran a row and column scan", sb.scans);
    if (sb.errors == 0) begin
      $display("[counted_adjacency_matrix_store] OK");
    end else begin
      $display("[counted_adjacency_matrix_store] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cams_pkg.sv
rtl/cams_ram.sv
rtl/cams_seq.sv
rtl/cams_dp.sv
rtl/counted_adjacency_matrix_store.sv
rtl/cams_chk.sv
test/testbench.sv
